@@ hw/rtl/lted_pkg.sv @@
// Shared types and constants of the LFSR timestamp event decoder.
package lted_pkg;

    localparam int LFSR_W    = 15;
    localparam int ROM_DEPTH = 32768;
    localparam int POS_W     = 16;
    localparam int COUNT_W   = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LFSR_W-1:0] LOCKUP_STATE     = 15'h7FFF;
    localparam logic [POS_W-1:0]  LOCKUP_POS       = 16'hFFFF;
    localparam logic [POS_W-1:0]  ENERGY_WRAP      = 16'd32767;
    localparam logic [15:0]       ENERGY_LIMIT_RST = 16'd1000;
    localparam logic [31:0]       WARMUP_RST       = 32'd2000;

    // m_tuser bit positions
    localparam int TUSER_ACCEPTED     = 0;
    localparam int TUSER_RESET_MARKER = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_LIMIT = 2'd0,
        CFG_WARMUP_WORDS = 2'd1
    } cfg_index_t;

    // m_tdata layout, last member in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic [COUNT_W-1:0] frame_hits;
        logic [COUNT_W-1:0] channel_hits;
        logic [5:0]         frame;
        logic [14:0]        hit_address;
        logic [1:0]         bad_flags;
        logic [4:0]         time_fine;
        logic [4:0]         energy_fine;
        logic [POS_W-1:0]   time_coarse;
        logic [POS_W-1:0]   energy;
        logic [COUNT_W-1:0] event_index;
    } result_t;

endpackage

@@ hw/rtl/lfsr_timestamp_event_decoder.sv @@
// Top level: readout word decoder with LFSR timestamp lookup and hit counters.
//
// Takes one 64-bit readout word per cycle while the output side is not stalled
// and returns one result per word, through the stage-1 registers and then the
// output register. The rate is set by the per-channel and per-frame counter
// read-modify-write, which has a one-entry bypass for back-to-back hits on the
// same counter; the two coarse timestamps are looked up in two copies of a
// 32768-entry decode memory. After reset an initialization pass fills the
// decode memories and clears the counters; s_tready stays low during it, while
// configuration writes are taken at all times (cfg_ready is always high).
// Configuration must only change while no word is in flight.
module lfsr_timestamp_event_decoder #(
    parameter int BOARD_COUNT = 32,
    parameter int FRAME_SLOTS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // byte_0 .. byte_7, 8 bits each from bit 0 up
    input  logic [lted_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_index, energy, time_coarse, energy_fine, time_fine, bad_flags,
    // hit_address, frame, channel_hits, frame_hits, zero pad
    output logic [lted_pkg::M_TDATA_W-1:0]  m_tdata,
    // accepted, reset_marker
    output logic [lted_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lted_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lted_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CH_DEPTH = BOARD_COUNT * 1024;
    localparam int CH_AW    = $clog2(CH_DEPTH);
    localparam int FR_AW    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int LW       = lted_pkg::LFSR_W;
    localparam int PW       = lted_pkg::POS_W;
    localparam int CW       = lted_pkg::COUNT_W;

    // configuration
    logic [15:0] energy_limit_reg;
    logic [31:0] warmup_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_limit_reg <= lted_pkg::ENERGY_LIMIT_RST;
            warmup_reg       <= lted_pkg::WARMUP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lted_pkg::CFG_ENERGY_LIMIT: energy_limit_reg <= cfg_data[15:0];
                lted_pkg::CFG_WARMUP_WORDS: warmup_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // init pass: walk the LFSR sequence into the decode memories, clear counters
    logic          clr_busy_reg;
    logic [LW-1:0] clr_idx_reg;
    logic [LW-1:0] lfsr_reg;
    logic          clr_last;
    logic [LW-1:0] rom_waddr;
    logic [PW-1:0] rom_wdata;

    assign clr_last  = (clr_idx_reg == lted_pkg::LOCKUP_STATE);
    assign rom_waddr = clr_last ? lted_pkg::LOCKUP_STATE : lfsr_reg;
    assign rom_wdata = clr_last ? lted_pkg::LOCKUP_POS : {1'b0, clr_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            lfsr_reg     <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            lfsr_reg    <= {lfsr_reg[LW-2:0], ~(lfsr_reg[LW-2] ^ lfsr_reg[LW-1])};
            if (clr_last) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // input decode
    logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7;
    assign {b7, b6, b5, b4, b3, b2, b1, b0} = s_tdata;

    logic          in_xfer;
    logic [LW-1:0] e_lfsr, t_lfsr;
    logic          in_rm;
    logic [4:0]    board_lut [32];
    logic [FR_AW-1:0] frame_lut [64];
    logic [14:0]   in_addr;
    logic [CH_AW-1:0] in_ch_idx;
    logic [FR_AW-1:0] in_fr_idx;

    for (genvar g = 0; g < 32; g++) begin : g_board_lut
        assign board_lut[g] = 5'(g % BOARD_COUNT);
    end
    for (genvar g = 0; g < 64; g++) begin : g_frame_lut
        assign frame_lut[g] = FR_AW'(g % FRAME_SLOTS);
    end

    assign in_xfer   = s_tvalid && s_tready;
    assign e_lfsr    = {b1[3:0], b2, b3[7:5]};
    assign t_lfsr    = {b6[0], b7, b0[7:2]};
    assign in_rm     = (b5 == 8'hFF) && (b6 == 8'hFF) && (b7 == 8'hFF) && (b0[7:2] == 6'h3F);
    assign in_addr   = {board_lut[b4[6:2]], b4[1:0], b5[7:6], b6[7:2]};
    assign in_ch_idx = in_addr[CH_AW-1:0];
    assign in_fr_idx = frame_lut[b5[5:0]];

    // memories
    logic [PW-1:0]    ecc, tcc;
    logic [CW-1:0]    ch_rdata, fr_rdata;
    logic             ch_we, fr_we;
    logic [CH_AW-1:0] ch_waddr;
    logic [FR_AW-1:0] fr_waddr;
    logic [CW-1:0]    ch_wdata, fr_wdata;

    lted_ram #(.WIDTH(PW), .DEPTH(lted_pkg::ROM_DEPTH)) u_rom_e (
        .aclk(aclk), .we(clr_busy_reg), .waddr(rom_waddr), .wdata(rom_wdata),
        .re(in_xfer), .raddr(e_lfsr), .rdata(ecc)
    );

    lted_ram #(.WIDTH(PW), .DEPTH(lted_pkg::ROM_DEPTH)) u_rom_t (
        .aclk(aclk), .we(clr_busy_reg), .waddr(rom_waddr), .wdata(rom_wdata),
        .re(in_xfer), .raddr(t_lfsr), .rdata(tcc)
    );

    lted_ram #(.WIDTH(CW), .DEPTH(CH_DEPTH)) u_ch_cnt (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .re(in_xfer), .raddr(in_ch_idx), .rdata(ch_rdata)
    );

    lted_ram #(.WIDTH(CW), .DEPTH(FRAME_SLOTS)) u_fr_cnt (
        .aclk(aclk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .re(in_xfer), .raddr(in_fr_idx), .rdata(fr_rdata)
    );

    // word counter, counted at input transfer
    logic [CW-1:0] word_cnt_reg;
    logic [CW-1:0] word_cnt_next;

    assign word_cnt_next = word_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_cnt_reg <= '0;
        end else if (in_xfer) begin
            word_cnt_reg <= word_cnt_next;
        end
    end

    // stage 1: memory data back, decide and update counters
    logic             s1_valid_reg;
    logic             s1_rm_reg;
    logic             s1_warm_reg;
    logic [4:0]       s1_efine_reg;
    logic [4:0]       s1_tfine_reg;
    logic [1:0]       s1_bad_reg;
    logic [14:0]      s1_addr_reg;
    logic [5:0]       s1_frame_reg;
    logic [CH_AW-1:0] s1_ch_idx_reg;
    logic [FR_AW-1:0] s1_fr_idx_reg;
    logic             s1_ch_fwd_reg, s1_fr_fwd_reg;
    logic [CW-1:0]    s1_ch_fwd_val_reg, s1_fr_fwd_val_reg;

    logic          s1_advance;
    logic [PW-1:0] s1_energy;
    logic          s1_acc;
    logic [CW-1:0] ch_inc, fr_inc;
    logic [CW-1:0] acc_cnt_reg;

    logic                    m_valid_reg;
    lted_pkg::result_t       m_data_reg;
    lted_pkg::result_t       m_data_next;
    logic [1:0]              m_user_reg;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !clr_busy_reg && (!s1_valid_reg || s1_advance);

    assign s1_energy = (ecc > tcc) ? PW'(ecc - tcc) : PW'(lted_pkg::ENERGY_WRAP + ecc - tcc);
    assign s1_acc    = !s1_rm_reg && (s1_energy < energy_limit_reg) && s1_warm_reg;
    assign ch_inc    = (s1_ch_fwd_reg ? s1_ch_fwd_val_reg : ch_rdata) + 1'b1;
    assign fr_inc    = (s1_fr_fwd_reg ? s1_fr_fwd_val_reg : fr_rdata) + 1'b1;

    assign ch_we    = clr_busy_reg ? ({1'b0, clr_idx_reg} < 16'(CH_DEPTH))
                                   : (s1_advance && s1_acc);
    assign ch_waddr = clr_busy_reg ? clr_idx_reg[CH_AW-1:0] : s1_ch_idx_reg;
    assign ch_wdata = clr_busy_reg ? '0 : ch_inc;
    assign fr_we    = clr_busy_reg ? ({1'b0, clr_idx_reg} < 16'(FRAME_SLOTS))
                                   : (s1_advance && s1_acc);
    assign fr_waddr = clr_busy_reg ? clr_idx_reg[FR_AW-1:0] : s1_fr_idx_reg;
    assign fr_wdata = clr_busy_reg ? '0 : fr_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // the counter write of the advancing item lands at the same edge as the read
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_rm_reg         <= in_rm;
            s1_warm_reg       <= word_cnt_next > warmup_reg;
            s1_efine_reg      <= b3[4:0];
            s1_tfine_reg      <= {b0[1:0], b1[7:5]};
            s1_bad_reg        <= {b6[1], b1[4]};
            s1_addr_reg       <= in_addr;
            s1_frame_reg      <= b5[5:0];
            s1_ch_idx_reg     <= in_ch_idx;
            s1_fr_idx_reg     <= in_fr_idx;
            s1_ch_fwd_reg     <= s1_advance && s1_acc && (s1_ch_idx_reg == in_ch_idx);
            s1_fr_fwd_reg     <= s1_advance && s1_acc && (s1_fr_idx_reg == in_fr_idx);
            s1_ch_fwd_val_reg <= ch_inc;
            s1_fr_fwd_val_reg <= fr_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg <= '0;
        end else if (s1_advance && s1_acc) begin
            acc_cnt_reg <= acc_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        m_data_next = '0;
        if (!s1_rm_reg) begin
            m_data_next.event_index  = acc_cnt_reg;
            m_data_next.energy       = s1_energy;
            m_data_next.time_coarse  = tcc;
            m_data_next.energy_fine  = s1_efine_reg;
            m_data_next.time_fine    = s1_tfine_reg;
            m_data_next.bad_flags    = s1_bad_reg;
            m_data_next.hit_address  = s1_addr_reg;
            m_data_next.frame        = s1_frame_reg;
            m_data_next.channel_hits = s1_acc ? ch_inc : '0;
            m_data_next.frame_hits   = s1_acc ? fr_inc : '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= m_data_next;
            m_user_reg <= {s1_rm_reg, s1_acc};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ hw/rtl/lted_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lted_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lted_checker.sv @@
// Port-level checks of the LFSR timestamp event decoder, bound to the top level.
module lted_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lted_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lted_pkg::M_TUSER_W-1:0] m_tuser
);

    lted_pkg::result_t res;
    logic              acc;
    logic              rm;
    logic              exp_known_reg;
    logic [31:0]       exp_idx_reg;

    assign res = m_tdata;
    assign acc = m_tuser[lted_pkg::TUSER_ACCEPTED];
    assign rm  = m_tuser[lted_pkg::TUSER_RESET_MARKER];

    // expected event index of the next non-marker result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_known_reg <= 1'b0;
            exp_idx_reg   <= '0;
        end else if (m_tvalid && m_tready && !rm) begin
            exp_known_reg <= 1'b1;
            exp_idx_reg   <= res.event_index + {31'd0, acc};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_marker_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rm |-> !acc && (m_tdata == '0))
        else $error("reset marker result carries data");

    a_reject_no_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !acc |-> (res.channel_hits == '0) && (res.frame_hits == '0))
        else $error("rejected event reports hit counts");

    a_index_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !rm && exp_known_reg |-> res.event_index == exp_idx_reg)
        else $error("event index out of sequence");

endmodule

bind lfsr_timestamp_event_decoder lted_checker u_lted_checker (.*);
